// ===== rtl/snow_cover_block_vote_unit_defines.svh =====
// Assertion macros shared by the snow cover vote RTL
`ifndef SNOW_COVER_BLOCK_VOTE_UNIT_DEFINES_SVH
`define SNOW_COVER_BLOCK_VOTE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SCBV_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("scbv check failed");

// next-cycle implication
`define SCBV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("scbv check failed");

`else

`define SCBV_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define SCBV_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/scbv_pkg.sv =====
// Shared constants, types and codes for the snow cover vote block
`default_nettype none

package scbv_pkg;

    localparam int GRID_MAX_WIDTH  = 64;
    localparam int GRID_MAX_LENGTH = 64;
    localparam int COUNT_BITS      = 24;
    localparam int POS_BITS        = 12;

    localparam int CELLS_MAX  = GRID_MAX_WIDTH * GRID_MAX_LENGTH;
    localparam int ADDR_BITS  = $clog2(CELLS_MAX);
    localparam int POS_LIMIT  = 1 << POS_BITS;

    // fixed field widths
    localparam int AGE_BITS    = 8;
    localparam int MAP_BITS    = 8;
    localparam int GRID_BITS   = 7;
    localparam int CELL_BITS   = 13;
    localparam int CLASS_BITS  = 2;
    localparam int INDEX_BITS  = 12;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 24;
    localparam int S_DATA_BITS = 16;
    localparam int M_DATA_BITS = 16;

    // product and compare widths
    localparam int NCELL_BITS = 2 * GRID_BITS;
    localparam int CMP_BITS   = (POS_BITS + 1 > CELL_BITS) ? POS_BITS + 1 : CELL_BITS;

    localparam int MEM_BITS = 2 * COUNT_BITS;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_MAX_AGE     = 3'd0,
        REG_AGE_OFFSET  = 3'd1,
        REG_GRID_WIDTH  = 3'd2,
        REG_GRID_LENGTH = 3'd3,
        REG_CELL_WIDTH  = 3'd4,
        REG_CELL_LENGTH = 3'd5,
        REG_MIN_SNOW    = 3'd6,
        REG_MIN_BARE    = 3'd7
    } cfg_idx_t;

    typedef enum logic [CLASS_BITS-1:0] {
        CLS_BARE   = 2'd0,
        CLS_SNOW   = 2'd1,
        CLS_NODATA = 2'd2
    } cell_class_t;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    localparam logic [MAP_BITS-1:0] MAP_BARE = 8'd0;
    localparam logic [MAP_BITS-1:0] MAP_SNOW = 8'd1;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic clear_step;
        logic mem_rd;
        logic commit;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic is_fetch;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/snow_cover_block_vote_unit.sv =====
// Top level: per-cell snow/bare vote over a raster stream
//
//   port group   dir   tdata                          tuser      tlast
//   s_*          in    [7:0] map byte [15:8] age byte [0] func   row_end
//   m_*          out   [1:0] class [13:2] index       -          last_cell
//   cfg_*        in    write enable, 3-bit index, 24-bit data
//
// Each request passes through three steps (accept, count memory read, update/write),
// set by the single-port count memory read-modify-write.
// A fetch stays in the update step while the result register is still full.
// After reset a clearing pass zeroes the 4096-entry count memory, one entry
// per cycle: s_tready stays low during the pass; config writes are taken.
`default_nettype none

`include "snow_cover_block_vote_unit_defines.svh"

module snow_cover_block_vote_unit (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    input  wire logic [scbv_pkg::S_DATA_BITS-1:0]       s_tdata,  // map byte, age byte
    input  wire logic [0:0]                             s_tuser,  // func
    input  wire logic                                   s_tlast,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    output logic [scbv_pkg::M_DATA_BITS-1:0]            m_tdata,  // cell_class, cell_index, pad
    output logic                                        m_tlast,
    input  wire logic                                   cfg_we,
    input  wire logic [scbv_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  wire logic [scbv_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);

    scbv_pkg::cmd_t cmd;
    scbv_pkg::sts_t sts;

    logic [scbv_pkg::CLASS_BITS-1:0] out_class;
    logic [scbv_pkg::INDEX_BITS-1:0] out_index;

    scbv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    scbv_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_func    (s_tuser[0]),
        .in_map     (s_tdata[scbv_pkg::MAP_BITS-1:0]),
        .in_age     (s_tdata[scbv_pkg::MAP_BITS +: scbv_pkg::AGE_BITS]),
        .in_row_end (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_class  (out_class),
        .out_index  (out_index),
        .out_last   (m_tlast)
    );

    assign m_tdata = scbv_pkg::M_DATA_BITS'({out_index, out_class});

    // one request in flight: ready drops right after an accept
    `SCBV_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // the clearing pass never overlaps request intake
    `SCBV_ASSERT_NOW(a_clear_blocks_input, aclk, aresetn, cmd.clear_step, !s_tready)
    // a committed fetch always shows up as a result
    `SCBV_ASSERT_NEXT(a_fetch_gives_result, aclk, aresetn, cmd.commit && sts.is_fetch, m_tvalid)
    // a fetch never overwrites a result that is still waiting
    `SCBV_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd.commit && sts.is_fetch && m_tvalid, m_tready)

endmodule

`default_nettype wire

// ===== rtl/scbv_ctrl.sv =====
// Sequencer: memory clear after reset, then accept / read / update per request
`default_nettype none

module scbv_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  scbv_pkg::sts_t     sts,
    output scbv_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_RD    = 4'b0100,
        ST_MOD   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd.accept     = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.mem_rd     = 1'b0;
        cmd.commit     = 1'b0;
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) state_next = ST_RD;
            end
            ST_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD: begin
                // a fetch waits here until the output register can take it
                if (!sts.is_fetch || sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/scbv_datapath.sv =====
// Config registers, position tracking, count memory and result register
`default_nettype none

module scbv_datapath (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  scbv_pkg::cmd_t                              cmd,
    output scbv_pkg::sts_t                              sts,
    input  wire logic                                   cfg_we,
    input  wire logic [scbv_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  wire logic [scbv_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  wire logic                                   in_func,
    input  wire logic [scbv_pkg::MAP_BITS-1:0]          in_map,
    input  wire logic [scbv_pkg::AGE_BITS-1:0]          in_age,
    input  wire logic                                   in_row_end,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic [scbv_pkg::CLASS_BITS-1:0]             out_class,
    output logic [scbv_pkg::INDEX_BITS-1:0]             out_index,
    output logic                                        out_last
);

    // configuration
    logic [scbv_pkg::AGE_BITS-1:0]   max_age_reg, age_offset_reg;
    logic [scbv_pkg::GRID_BITS-1:0]  grid_width_reg, grid_length_reg;
    logic [scbv_pkg::CELL_BITS-1:0]  cell_width_reg, cell_length_reg;
    logic [scbv_pkg::COUNT_BITS-1:0] min_snow_reg, min_bare_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_age_reg     <= '1;
            age_offset_reg  <= '0;
            grid_width_reg  <= scbv_pkg::GRID_BITS'(scbv_pkg::GRID_MAX_WIDTH);
            grid_length_reg <= scbv_pkg::GRID_BITS'(scbv_pkg::GRID_MAX_LENGTH);
            cell_width_reg  <= scbv_pkg::CELL_BITS'(1);
            cell_length_reg <= scbv_pkg::CELL_BITS'(1);
            min_snow_reg    <= '0;
            min_bare_reg    <= '0;
        end else if (cfg_we) begin
            unique case (scbv_pkg::cfg_idx_t'(cfg_addr))
                scbv_pkg::REG_MAX_AGE:     max_age_reg <= cfg_wdata[scbv_pkg::AGE_BITS-1:0];
                scbv_pkg::REG_AGE_OFFSET:  age_offset_reg <= cfg_wdata[scbv_pkg::AGE_BITS-1:0];
                scbv_pkg::REG_GRID_WIDTH:  grid_width_reg <= cfg_wdata[scbv_pkg::GRID_BITS-1:0];
                scbv_pkg::REG_GRID_LENGTH: grid_length_reg <= cfg_wdata[scbv_pkg::GRID_BITS-1:0];
                scbv_pkg::REG_CELL_WIDTH:  cell_width_reg <= cfg_wdata[scbv_pkg::CELL_BITS-1:0];
                scbv_pkg::REG_CELL_LENGTH: cell_length_reg <= cfg_wdata[scbv_pkg::CELL_BITS-1:0];
                scbv_pkg::REG_MIN_SNOW:    min_snow_reg <= cfg_wdata[scbv_pkg::COUNT_BITS-1:0];
                scbv_pkg::REG_MIN_BARE:    min_bare_reg <= cfg_wdata[scbv_pkg::COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry: zero acts as one, oversize acts as the maximum
    logic [scbv_pkg::GRID_BITS-1:0]  gw, gl;
    logic [scbv_pkg::CMP_BITS-1:0]   cw, cl;
    logic [scbv_pkg::NCELL_BITS-1:0] ncells;

    always_comb begin
        if (grid_width_reg == '0)
            gw = scbv_pkg::GRID_BITS'(1);
        else if (int'(grid_width_reg) > scbv_pkg::GRID_MAX_WIDTH)
            gw = scbv_pkg::GRID_BITS'(scbv_pkg::GRID_MAX_WIDTH);
        else
            gw = grid_width_reg;
        if (grid_length_reg == '0)
            gl = scbv_pkg::GRID_BITS'(1);
        else if (int'(grid_length_reg) > scbv_pkg::GRID_MAX_LENGTH)
            gl = scbv_pkg::GRID_BITS'(scbv_pkg::GRID_MAX_LENGTH);
        else
            gl = grid_length_reg;
        if (cell_width_reg == '0)
            cw = scbv_pkg::CMP_BITS'(1);
        else if (int'(cell_width_reg) > scbv_pkg::POS_LIMIT)
            cw = scbv_pkg::CMP_BITS'(scbv_pkg::POS_LIMIT);
        else
            cw = scbv_pkg::CMP_BITS'(cell_width_reg);
        if (cell_length_reg == '0)
            cl = scbv_pkg::CMP_BITS'(1);
        else if (int'(cell_length_reg) > scbv_pkg::POS_LIMIT)
            cl = scbv_pkg::CMP_BITS'(scbv_pkg::POS_LIMIT);
        else
            cl = scbv_pkg::CMP_BITS'(cell_length_reg);
        ncells = scbv_pkg::NCELL_BITS'(gw) * scbv_pkg::NCELL_BITS'(gl);
    end

    // pixel position and read pointer
    logic [scbv_pkg::POS_BITS-1:0]  col_in_cell_reg, row_in_cell_reg;
    logic [scbv_pkg::GRID_BITS-1:0] cell_col_reg, cell_row_reg;
    logic [scbv_pkg::ADDR_BITS-1:0] read_ptr_reg;

    logic [scbv_pkg::CMP_BITS-1:0]   col_inc, row_inc;
    logic [scbv_pkg::NCELL_BITS-1:0] pix_idx;
    logic [scbv_pkg::ADDR_BITS-1:0]  rp_eff;
    logic [scbv_pkg::AGE_BITS-1:0]   age_adj;
    logic                            pix_in_grid, pix_counts, fetch_last;

    always_comb begin
        col_inc     = scbv_pkg::CMP_BITS'(col_in_cell_reg) + scbv_pkg::CMP_BITS'(1);
        row_inc     = scbv_pkg::CMP_BITS'(row_in_cell_reg) + scbv_pkg::CMP_BITS'(1);
        pix_idx     = scbv_pkg::NCELL_BITS'(cell_row_reg) * scbv_pkg::NCELL_BITS'(gw)
                    + scbv_pkg::NCELL_BITS'(cell_col_reg);
        age_adj     = in_age + age_offset_reg;
        pix_in_grid = (cell_col_reg < gw) && (cell_row_reg < gl)
                    && (int'(pix_idx) < scbv_pkg::CELLS_MAX);
        pix_counts  = (age_adj <= max_age_reg) && pix_in_grid;
        // a shrunken grid restarts the read at cell 0
        rp_eff      = (scbv_pkg::NCELL_BITS'(read_ptr_reg) >= ncells) ? '0 : read_ptr_reg;
        fetch_last  = (scbv_pkg::NCELL_BITS'(rp_eff) == ncells - scbv_pkg::NCELL_BITS'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_in_cell_reg <= '0;
            row_in_cell_reg <= '0;
            cell_col_reg    <= '0;
            cell_row_reg    <= '0;
            read_ptr_reg    <= '0;
        end else if (cmd.accept) begin
            if (in_func == scbv_pkg::FUNC_PIXEL) begin
                if (in_row_end) begin
                    col_in_cell_reg <= '0;
                    cell_col_reg    <= '0;
                    if (row_inc >= cl) begin
                        row_in_cell_reg <= '0;
                        if (cell_row_reg < gl) cell_row_reg <= cell_row_reg + 1'b1;
                    end else begin
                        row_in_cell_reg <= scbv_pkg::POS_BITS'(row_inc);
                    end
                end else begin
                    if (col_inc >= cw) begin
                        col_in_cell_reg <= '0;
                        if (cell_col_reg < gw) cell_col_reg <= cell_col_reg + 1'b1;
                    end else begin
                        col_in_cell_reg <= scbv_pkg::POS_BITS'(col_inc);
                    end
                end
            end else if (fetch_last) begin
                read_ptr_reg    <= '0;
                col_in_cell_reg <= '0;
                row_in_cell_reg <= '0;
                cell_col_reg    <= '0;
                cell_row_reg    <= '0;
            end else begin
                read_ptr_reg <= rp_eff + 1'b1;
            end
        end
    end

    // request held for the read-modify-write
    logic [scbv_pkg::ADDR_BITS-1:0] addr_reg;
    logic                           is_fetch_reg, inc_snow_reg, inc_bare_reg, last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            is_fetch_reg <= (in_func == scbv_pkg::FUNC_FETCH);
            inc_snow_reg <= pix_counts && (in_map == scbv_pkg::MAP_SNOW);
            inc_bare_reg <= pix_counts && (in_map == scbv_pkg::MAP_BARE);
            last_reg     <= fetch_last;
            addr_reg     <= (in_func == scbv_pkg::FUNC_FETCH)
                          ? rp_eff : scbv_pkg::ADDR_BITS'(pix_idx);
        end
    end

    // clear sweep counter
    logic [scbv_pkg::ADDR_BITS-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // count memory: {bare, snow}
    logic [scbv_pkg::MEM_BITS-1:0]   count_mem [scbv_pkg::CELLS_MAX];
    logic [scbv_pkg::MEM_BITS-1:0]   rd_data_reg, mem_wdata;
    logic [scbv_pkg::ADDR_BITS-1:0]  mem_waddr;
    logic                            mem_we;
    logic [scbv_pkg::COUNT_BITS-1:0] snow_cnt, bare_cnt, snow_new, bare_new;
    logic [scbv_pkg::CLASS_BITS-1:0] cls;

    always_comb begin
        snow_cnt = rd_data_reg[scbv_pkg::COUNT_BITS-1:0];
        bare_cnt = rd_data_reg[scbv_pkg::MEM_BITS-1:scbv_pkg::COUNT_BITS];
        snow_new = (inc_snow_reg && snow_cnt != '1) ? snow_cnt + 1'b1 : snow_cnt;
        bare_new = (inc_bare_reg && bare_cnt != '1) ? bare_cnt + 1'b1 : bare_cnt;
        priority if (snow_cnt > min_snow_reg) cls = scbv_pkg::CLS_SNOW;
        else if (bare_cnt >= min_bare_reg)    cls = scbv_pkg::CLS_BARE;
        else                                  cls = scbv_pkg::CLS_NODATA;

        mem_we    = cmd.clear_step || cmd.commit;
        mem_waddr = cmd.clear_step ? clr_cnt_reg : addr_reg;
        // fetch reads clear the cell
        mem_wdata = (cmd.clear_step || is_fetch_reg) ? '0 : {bare_new, snow_new};
    end

    always_ff @(posedge aclk) begin
        if (mem_we) count_mem[mem_waddr] <= mem_wdata;
        if (cmd.mem_rd) rd_data_reg <= count_mem[addr_reg];
    end

    // result register
    logic                            m_valid_reg;
    logic [scbv_pkg::CLASS_BITS-1:0] m_class_reg;
    logic [scbv_pkg::INDEX_BITS-1:0] m_index_reg;
    logic                            m_last_reg;
    logic                            load_out;

    assign load_out = cmd.commit && is_fetch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_class_reg <= cls;
            m_index_reg <= scbv_pkg::INDEX_BITS'(addr_reg);
            m_last_reg  <= last_reg;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_class = m_class_reg;
    assign out_index = m_index_reg;
    assign out_last  = m_last_reg;

    assign sts.clear_last = (int'(clr_cnt_reg) == scbv_pkg::CELLS_MAX - 1);
    assign sts.is_fetch   = is_fetch_reg;
    assign sts.out_free   = !m_valid_reg || out_ready;

endmodule

`default_nettype wire

// ===== bench/tb_snow_cover_block_vote_unit.sv =====
// Self-checking testbench for the snow cover block vote unit: raster streams in, cell classes out
`default_nettype none

module tb_snow_cover_block_vote_unit;
    import scbv_pkg::*;

    localparam int ITEM_GOAL  = 550;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD  = 400;

    typedef struct packed {
        logic                func;
        logic [MAP_BITS-1:0] mapb;
        logic [AGE_BITS-1:0] ageb;
        logic                row_end;
    } raster_req_t;

    typedef struct packed {
        cell_class_t           cls;
        logic [INDEX_BITS-1:0] idx;
        logic                  last;
    } cell_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_tvalid = 1'b0;
    wire logic                s_tready;
    logic [S_DATA_BITS-1:0]   s_tdata = '0;   // [7:0] map byte, [15:8] age byte
    logic [0:0]               s_tuser = '0;   // [0] func
    logic                     s_tlast = 1'b0;
    wire logic                m_tvalid;
    logic                     m_tready = 1'b0;
    wire logic [M_DATA_BITS-1:0] m_tdata;     // [1:0] cell_class, [13:2] cell_index
    wire logic                m_tlast;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

    snow_cover_block_vote_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // mirror of the register file
    logic [AGE_BITS-1:0]   age_limit;
    logic [AGE_BITS-1:0]   age_shift;
    logic [GRID_BITS-1:0]  grid_w_reg;
    logic [GRID_BITS-1:0]  grid_l_reg;
    logic [CELL_BITS-1:0]  cell_w_reg;
    logic [CELL_BITS-1:0]  cell_l_reg;
    logic [COUNT_BITS-1:0] snow_floor;
    logic [COUNT_BITS-1:0] bare_floor;

    // mirror of the tallies and raster position
    logic [COUNT_BITS-1:0] snow_tally [CELLS_MAX];
    logic [COUNT_BITS-1:0] bare_tally [CELLS_MAX];
    int unsigned px_in_cell, col_cell, line_in_cell, row_cell, fetch_ptr;

    raster_req_t  raster_q[$];
    cell_result_t cell_results_q[$];
    int queued_total;
    int mismatch_count;
    int idle_cycles;

    // driver / receiver state
    raster_req_t next_req;
    int gap_left, burst_left;
    int hold_left, mode_left, stall_mode;
    int long_hold_req, long_hold_seen;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned eff_size(int unsigned raw, int unsigned top);
        if (raw == 0) return 1;
        if (raw > top) return top;
        return raw;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < 30) $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Update the tallies for one accepted request; a fetch yields one expected cell.
    task automatic tally_item(logic func, logic [MAP_BITS-1:0] mapb,
                              logic [AGE_BITS-1:0] ageb, logic row_end);
        int unsigned gw, gl, cw, cl, ncells, rp, slot;
        logic [AGE_BITS-1:0] adj;
        cell_result_t res;
        gw = eff_size(32'(grid_w_reg), GRID_MAX_WIDTH);
        gl = eff_size(32'(grid_l_reg), GRID_MAX_LENGTH);
        cw = eff_size(32'(cell_w_reg), POS_LIMIT);
        cl = eff_size(32'(cell_l_reg), POS_LIMIT);
        ncells = gw * gl;
        if (func == FUNC_PIXEL) begin
            adj = ageb + age_shift;
            if (adj <= age_limit && col_cell < gw && row_cell < gl) begin
                slot = row_cell * gw + col_cell;
                if (mapb == MAP_SNOW) begin
                    if (snow_tally[slot] != '1) snow_tally[slot]++;
                end else if (mapb == MAP_BARE) begin
                    if (bare_tally[slot] != '1) bare_tally[slot]++;
                end
            end
            if (row_end) begin
                px_in_cell = 0;
                col_cell = 0;
                line_in_cell++;
                if (line_in_cell >= cl) begin
                    line_in_cell = 0;
                    if (row_cell < gl) row_cell++;
                end
            end else begin
                px_in_cell++;
                if (px_in_cell >= cw) begin
                    px_in_cell = 0;
                    if (col_cell < gw) col_cell++;
                end
            end
        end else begin
            rp = fetch_ptr;
            if (rp >= ncells) rp = 0;    // grid shrank under the pointer
            if (snow_tally[rp] > snow_floor) res.cls = CLS_SNOW;
            else if (bare_tally[rp] >= bare_floor) res.cls = CLS_BARE;
            else res.cls = CLS_NODATA;
            snow_tally[rp] = '0;
            bare_tally[rp] = '0;
            res.idx = INDEX_BITS'(rp);
            res.last = (rp == ncells - 1);
            cell_results_q.push_back(res);
            if (res.last) begin
                fetch_ptr = 0;
                px_in_cell = 0;
                col_cell = 0;
                line_in_cell = 0;
                row_cell = 0;
            end else begin
                fetch_ptr = rp + 1;
            end
        end
    endtask

    task automatic set_reg(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_MAX_AGE:     age_limit = val[AGE_BITS-1:0];
            REG_AGE_OFFSET:  age_shift = val[AGE_BITS-1:0];
            REG_GRID_WIDTH:  grid_w_reg = val[GRID_BITS-1:0];
            REG_GRID_LENGTH: grid_l_reg = val[GRID_BITS-1:0];
            REG_CELL_WIDTH:  cell_w_reg = val[CELL_BITS-1:0];
            REG_CELL_LENGTH: cell_l_reg = val[CELL_BITS-1:0];
            REG_MIN_SNOW:    snow_floor = val[COUNT_BITS-1:0];
            REG_MIN_BARE:    bare_floor = val[COUNT_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic load_regs(logic [23:0] ma, logic [23:0] ao, logic [23:0] gw,
                             logic [23:0] gl, logic [23:0] cw, logic [23:0] cl,
                             logic [23:0] ms, logic [23:0] mb);
        set_reg(REG_MAX_AGE, ma);
        set_reg(REG_AGE_OFFSET, ao);
        set_reg(REG_GRID_WIDTH, gw);
        set_reg(REG_GRID_LENGTH, gl);
        set_reg(REG_CELL_WIDTH, cw);
        set_reg(REG_CELL_LENGTH, cl);
        set_reg(REG_MIN_SNOW, ms);
        set_reg(REG_MIN_BARE, mb);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_item(logic func, logic [MAP_BITS-1:0] mapb,
                              logic [AGE_BITS-1:0] ageb, logic row_end);
        raster_q.push_back('{func, mapb, ageb, row_end});
        queued_total++;
    endtask

    // One raster frame of roughly cols x rows pixels, with some noise, then fetches.
    task automatic queue_frame(int cols, int rows, int fetches);
        int n, pick;
        logic [MAP_BITS-1:0] mapb;
        for (int r = 0; r < rows; r++) begin
            n = cols - 1 + $urandom_range(0, 2);
            if (n < 1) n = 1;
            for (int c = 0; c < n; c++) begin
                if ($urandom_range(0, 15) == 0)
                    queue_item(1'($urandom_range(0, 1)), MAP_BITS'($urandom),
                               AGE_BITS'($urandom), 1'($urandom_range(0, 1)));
                pick = $urandom_range(0, 9);
                mapb = (pick < 4) ? MAP_SNOW : (pick < 8) ? MAP_BARE : MAP_BITS'($urandom);
                queue_item(FUNC_PIXEL, mapb, AGE_BITS'($urandom), c == n - 1);
            end
        end
        repeat (fetches)
            queue_item(FUNC_FETCH, MAP_BITS'($urandom), AGE_BITS'($urandom),
                       1'($urandom_range(0, 1)));
    endtask

    // Wait until every request is taken and every cell reported, then let the pipe empty.
    task automatic settle();
        while (raster_q.size() != 0 || s_tvalid || cell_results_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // request driver, with the input-side predictor hook
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
            burst_left = 0;
        end else begin
            if (s_tvalid && s_tready) tally_item(s_tuser[0], s_tdata[7:0], s_tdata[15:8], s_tlast);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (raster_q.size() > 0) begin
                    next_req = raster_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_req.func;
                    s_tdata <= {next_req.ageb, next_req.mapb};
                    s_tlast <= next_req.row_end;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver: random stall modes plus an on-demand long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left = 0;
            mode_left = 0;
            stall_mode = 0;
            long_hold_seen = 0;
        end else if (long_hold_seen != long_hold_req || hold_left > 0) begin
            if (long_hold_seen != long_hold_req) begin
                long_hold_seen = long_hold_req;
                hold_left = LONG_HOLD;
            end
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result checker
    always @(posedge aclk) begin
        cell_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (cell_results_q.size() == 0) begin
                report_mismatch($sformatf("unexpected cell index %0d", m_tdata[13:2]));
            end else begin
                want = cell_results_q.pop_front();
                if (m_tdata[1:0] !== want.cls)
                    report_mismatch($sformatf("cell %0d class %0d, want %0d",
                                              want.idx, m_tdata[1:0], want.cls));
                if (m_tdata[13:2] !== want.idx)
                    report_mismatch($sformatf("cell index %0d, want %0d",
                                              m_tdata[13:2], want.idx));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("cell %0d last %b, want %b",
                                              want.idx, m_tlast, want.last));
            end
        end
    end

    // watchdog: nothing accepted on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int gw_raw, gl_raw, cw_raw, cl_raw, gw, gl, cw, cl, ncells;
        age_limit = 8'd255;
        age_shift = '0;
        grid_w_reg = 7'd64;
        grid_l_reg = 7'd64;
        cell_w_reg = 13'd1;
        cell_l_reg = 13'd1;
        snow_floor = '0;
        bare_floor = '0;
        for (int i = 0; i < CELLS_MAX; i++) begin
            snow_tally[i] = '0;
            bare_tally[i] = '0;
        end
        px_in_cell = 0;
        col_cell = 0;
        line_in_cell = 0;
        row_cell = 0;
        fetch_ptr = 0;
        queued_total = 0;
        mismatch_count = 0;
        idle_cycles = 0;
        long_hold_req = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // 2x2 grid of 2x1 cells: age limit edge, offset wrap, ignored map byte,
        // pixels and rows past the grid, every class, wrap after the last cell
        load_regs(200, 100, 2, 2, 2, 1, 0, 1);
        queue_item(FUNC_PIXEL, MAP_SNOW, 8'd100, 1'b0);
        queue_item(FUNC_PIXEL, MAP_BARE, 8'd200, 1'b0);
        queue_item(FUNC_PIXEL, 8'hFF, 8'hFF, 1'b0);
        queue_item(FUNC_PIXEL, MAP_BARE, 8'd101, 1'b0);
        queue_item(FUNC_PIXEL, MAP_SNOW, 8'd0, 1'b0);
        queue_item(FUNC_PIXEL, MAP_BARE, 8'd0, 1'b1);
        queue_item(FUNC_PIXEL, MAP_BARE, 8'd0, 1'b1);
        queue_item(FUNC_PIXEL, MAP_SNOW, 8'd0, 1'b1);
        queue_item(FUNC_PIXEL, MAP_SNOW, 8'd0, 1'b1);
        repeat (5) queue_item(FUNC_FETCH, 8'h00, 8'h00, 1'b0);
        settle();

        // zero and oversized geometry, max age 0, top snow threshold
        load_regs(0, 255, 0, 127, 0, 8191, 24'hFFFFFF, 0);
        queue_item(FUNC_PIXEL, MAP_SNOW, 8'd1, 1'b0);
        queue_item(FUNC_PIXEL, MAP_BARE, 8'd0, 1'b1);
        repeat (2) queue_item(FUNC_FETCH, 8'hFF, 8'hFF, 1'b1);
        settle();

        // grid shrinks to one cell under a live read pointer; top bare threshold
        load_regs(255, 0, 1, 0, 1, 1, 0, 24'hFFFFFF);
        queue_item(FUNC_PIXEL, MAP_BARE, 8'h80, 1'b1);
        repeat (2) queue_item(FUNC_FETCH, 8'h00, 8'h00, 1'b0);
        settle();

        // receiver holds off while requests keep coming
        load_regs(24'($urandom_range(128, 255)), 0, 3, 2, 1, 1, 0, 1);
        long_hold_req++;
        queue_frame(3, 2, 6);
        queue_frame(3, 2, 6);
        settle();

        // widest grid, tallest cells
        load_regs(24'($urandom_range(0, 255)), 24'($urandom_range(0, 255)),
                  64, 1, 1, 4096, 1, 2);
        queue_frame(64, 1, 64);
        settle();

        // tallest grid, widest cells
        load_regs(24'($urandom_range(0, 255)), 24'($urandom_range(0, 255)),
                  1, 64, 4096, 1, 0, 1);
        queue_frame(2, 10, 64);
        settle();

        while (queued_total < ITEM_GOAL) begin
            gw_raw = $urandom_range(0, 4);
            gl_raw = $urandom_range(0, 3);
            cw_raw = $urandom_range(0, 3);
            cl_raw = $urandom_range(0, 2);
            gw = eff_size(gw_raw, GRID_MAX_WIDTH);
            gl = eff_size(gl_raw, GRID_MAX_LENGTH);
            cw = eff_size(cw_raw, POS_LIMIT);
            cl = eff_size(cl_raw, POS_LIMIT);
            ncells = gw * gl;
            load_regs(24'($urandom_range(0, 255)), 24'($urandom_range(0, 255)),
                      24'(gw_raw), 24'(gl_raw), 24'(cw_raw), 24'(cl_raw),
                      ($urandom_range(0, 5) == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 3)),
                      ($urandom_range(0, 5) == 0) ? 24'hFFFFFF : 24'($urandom_range(0, 3)));
            repeat ($urandom_range(1, 2)) begin
                queue_frame(gw * cw, gl * cl + $urandom_range(0, 1),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, ncells + 2)
                                                        : ncells);
            end
            settle();
        end

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
